// File: rtl/core/smeu_pkg.sv
// ----------------------------------------------------------------------------
// smeu_pkg
// Shared types and codes of the stack machine execute unit.
// ----------------------------------------------------------------------------
package smeu_pkg;

   localparam int PC_W = 13;
   localparam int WORD_W = 32;

   typedef enum logic [4:0] {
      OP_PUSH = 5'd0, OP_PUSHR = 5'd1, OP_POPR = 5'd2, OP_PUSHM = 5'd3,
      OP_POPM = 5'd4, OP_ADD = 5'd5, OP_SUB = 5'd6, OP_MUL = 5'd7,
      OP_DIV = 5'd8, OP_MOD = 5'd9, OP_SQRT = 5'd10, OP_SQR = 5'd11,
      OP_IN = 5'd12, OP_OUT = 5'd13, OP_JMP = 5'd14, OP_JB = 5'd15,
      OP_JBE = 5'd16, OP_JA = 5'd17, OP_JAE = 5'd18, OP_JE = 5'd19,
      OP_JNE = 5'd20, OP_CALL = 5'd21, OP_RET = 5'd22
   } op_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_UNDERFLOW = 3'd1, ST_OVERFLOW = 3'd2, ST_DIV_ZERO = 3'd3,
      ST_BAD_REG = 3'd4, ST_BAD_JUMP = 3'd5, ST_BAD_ADDR = 3'd6, ST_HALTED = 3'd7
   } status_type;

   // Request from sequencer to shared iterative arithmetic unit
   typedef struct packed {
      logic start;
      logic is_sqrt;
      logic is_mod;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
   } iter_req_type;

   typedef struct packed {
      logic done;
      logic [WORD_W-1:0] result;
   } iter_rsp_type;

endpackage

// File: rtl/core/smeu_iter_unit.sv
// ----------------------------------------------------------------------------
// smeu_iter_unit
// Shared one-bit-per-cycle unit for signed divide, modulo and integer root.
// ----------------------------------------------------------------------------
module smeu_iter_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  smeu_pkg::iter_req_type req,
   output smeu_pkg::iter_rsp_type rsp
);
   localparam int W = smeu_pkg::WORD_W;

   logic          busy_ff, busy_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          sqrt_ff, sqrt_in, mod_ff, mod_in, neg_q_ff, neg_q_in, neg_r_ff, neg_r_in;
   logic [W-1:0]  num_ff, num_in, den_ff, den_in, quo_ff, quo_in;
   logic [W+1:0]  rem_ff, rem_in;
   logic          done_ff, done_in;

   logic [W-1:0]  mag_a, mag_b;
   logic [W+1:0]  trial, trial_root;
   logic [W-1:0]  rem_low;

   assign mag_a = req.a[W-1] ? (~req.a + 1'b1) : req.a;
   assign mag_b = req.b[W-1] ? (~req.b + 1'b1) : req.b;

   // Divide: shift one numerator bit in; root: two bits in, trial 4q+1
   assign trial      = {rem_ff[W:0], num_ff[W-1]} - {2'b00, den_ff};
   assign trial_root = {rem_ff[W-1:0], num_ff[W-1:W-2]} - {quo_ff[W-1:0], 2'b01};
   assign rem_low    = rem_ff[W-1:0];

   always_comb begin
      busy_in = busy_ff; cnt_in = cnt_ff; sqrt_in = sqrt_ff; mod_in = mod_ff;
      neg_q_in = neg_q_ff; neg_r_in = neg_r_ff; num_in = num_ff; den_in = den_ff;
      quo_in = quo_ff; rem_in = rem_ff; done_in = 1'b0;
      if (req.start) begin
         busy_in = 1'b1;
         sqrt_in = req.is_sqrt;
         mod_in = req.is_mod;
         neg_q_in = req.a[W-1] ^ req.b[W-1];
         neg_r_in = req.a[W-1];
         num_in = req.is_sqrt ? req.b : mag_a;
         den_in = mag_b;
         quo_in = '0;
         rem_in = '0;
         cnt_in = req.is_sqrt ? 6'(W/2) : 6'(W);
      end else if (busy_ff) begin
         // Step one digit
         if (sqrt_ff) begin
            num_in = {num_ff[W-3:0], 2'b00};
            if (!trial_root[W+1]) begin
               rem_in = trial_root;
               quo_in = {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[W-1:0], num_ff[W-1:W-2]};
               quo_in = {quo_ff[W-2:0], 1'b0};
            end
         end else begin
            num_in = {num_ff[W-2:0], 1'b0};
            if (!trial[W+1]) begin
               rem_in = trial;
               quo_in = {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[W:0], num_ff[W-1]};
               quo_in = {quo_ff[W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Fix signs once finished
   logic [W-1:0] fixed;
   always_comb begin
      if (sqrt_ff)
         fixed = quo_ff;
      else if (mod_ff)
         fixed = neg_r_ff ? (~rem_low + 1'b1) : rem_low;
      else
         fixed = neg_q_ff ? (~quo_ff + 1'b1) : quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in; sqrt_ff <= sqrt_in; mod_ff <= mod_in;
      neg_q_ff <= neg_q_in; neg_r_ff <= neg_r_in; num_ff <= num_in;
      den_ff <= den_in; quo_ff <= quo_in; rem_ff <= rem_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = fixed;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without busy");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !done_ff) else $error("busy and done together");
   a_cnt_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != 6'd0) else $error("counter ran out while busy");
endmodule

// File: rtl/core/stack_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Executes one stack-machine instruction per item.
// ----------------------------------------------------------------------------
// Steps: most instructions pass read, execute, write back and hand off in turn;
//   div/mod and a non-negative sqrt add an iterate step in the bit-serial
//   divide/root unit unless they fault; an item while halted goes straight to
//   hand off. One item at a time: the next item is accepted the cycle after the
//   result is handed off to the output register. Reset clears pc, depths, fault,
//   then sweeps registers and data RAM one word a cycle.
module stack_machine_execute_unit #(
   parameter int DATA_STACK_DEPTH = 64,
   parameter int CALL_STACK_DEPTH = 32,
   parameter int RAM_WORDS        = 1024,
   parameter int CODE_WORDS       = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [12:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] operation, [36:5] immediate, [68:37] entered_value, zero fill
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [12:0] next_pc, [13] out_valid, [45:14] out_value, [48:46] status, fill
   output logic [55:0] rsp_tdata
);
   localparam int W  = smeu_pkg::WORD_W;
   localparam int PW = smeu_pkg::PC_W;
   localparam int DSA = $clog2(DATA_STACK_DEPTH);
   localparam int CSA = $clog2(CALL_STACK_DEPTH);
   localparam int RA  = $clog2(RAM_WORDS);

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC, S_ITER, S_WRITE, S_DONE}
      state_type;

   state_type state_ff;
   logic [PW-1:0] plen_ff, pc_ff, npc_ff;
   logic [DSA:0]  dd_ff;
   logic [CSA:0]  rd_ff;
   logic          fault_ff;
   logic [RA:0]   clr_ff;
   logic [4:0]    op_ff;
   logic [W-1:0]  imm_ff, ent_ff, a_ff, b_ff, r_ff, regv_ff, ramv_ff;
   logic [PW-1:0] ret_ff;
   logic [2:0]    st_ff;
   logic          outok_ff;
   logic [W-1:0]  outv_ff;
   logic          rv_ff;
   logic [55:0]   rdata_ff;

   logic [W-1:0]  dstack [DATA_STACK_DEPTH];
   logic [PW-1:0] cstack [CALL_STACK_DEPTH];
   logic [W-1:0]  regs [8];
   logic [W-1:0]  ram [RAM_WORDS];

   smeu_pkg::iter_req_type ireq;
   smeu_pkg::iter_rsp_type irsp;

   smeu_iter_unit u_iter (.clock(clock), .reset(reset), .req(ireq), .rsp(irsp));

   logic [4:0] op_w;
   assign op_w = op_ff;
   logic reg_ok, addr_ok;
   assign reg_ok  = (imm_ff < 32'd8);
   assign addr_ok = (regv_ff < 32'(RAM_WORDS));

   function automatic logic tgt_ok(input logic [31:0] t, input logic [12:0] pl);
      tgt_ok = !t[31] && (t <= {19'd0, pl});
   endfunction

   logic [PW-1:0] pc_next;
   logic two_word;
   assign two_word = (op_w <= 5'd4) || (op_w >= 5'd14 && op_w <= 5'd21);
   assign pc_next = pc_ff + (two_word ? PW'(2) : PW'(1));

   // Execute step: decide status, result and stack effects
   logic [2:0] ex_st;
   logic [W-1:0] ex_r;
   logic [PW-1:0] ex_npc;
   logic ex_iter, ex_outok;
   logic signed [W-1:0] sa, sb;
   logic take;
   logic [W-1:0] prod;
   assign sa = a_ff;
   assign sb = b_ff;
   always_comb begin
      case (op_w)
         smeu_pkg::OP_JB:  take = sa < sb;
         smeu_pkg::OP_JBE: take = sa <= sb;
         smeu_pkg::OP_JA:  take = sa > sb;
         smeu_pkg::OP_JAE: take = sa >= sb;
         smeu_pkg::OP_JE:  take = sa == sb;
         default:          take = sa != sb;
      endcase
   end
   assign prod = (op_w == smeu_pkg::OP_MUL) ? a_ff * b_ff : b_ff * b_ff;

   always_comb begin
      ex_st = smeu_pkg::ST_OK; ex_r = '0; ex_npc = pc_next; ex_iter = 1'b0; ex_outok = 1'b0;
      case (op_w)
         smeu_pkg::OP_PUSH, smeu_pkg::OP_PUSHR, smeu_pkg::OP_PUSHM, smeu_pkg::OP_IN: begin
            if ((op_w == smeu_pkg::OP_PUSHR || op_w == smeu_pkg::OP_PUSHM) && !reg_ok)
               ex_st = smeu_pkg::ST_BAD_REG;
            else if (op_w == smeu_pkg::OP_PUSHM && !addr_ok) ex_st = smeu_pkg::ST_BAD_ADDR;
            else if (dd_ff >= (DSA+1)'(DATA_STACK_DEPTH)) ex_st = smeu_pkg::ST_OVERFLOW;
            ex_r = (op_w == smeu_pkg::OP_PUSH) ? imm_ff : (op_w == smeu_pkg::OP_PUSHR) ? regv_ff
                 : (op_w == smeu_pkg::OP_PUSHM) ? ramv_ff : ent_ff;
         end
         smeu_pkg::OP_POPR: if (dd_ff != 0 && !reg_ok) ex_st = smeu_pkg::ST_BAD_REG;
         smeu_pkg::OP_POPM: begin
            if (!reg_ok) ex_st = smeu_pkg::ST_BAD_REG;
            else if (!addr_ok) ex_st = smeu_pkg::ST_BAD_ADDR;
            else if (dd_ff == 0) ex_st = smeu_pkg::ST_UNDERFLOW;
         end
         smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_DIV,
         smeu_pkg::OP_MOD: begin
            if (dd_ff < 2) ex_st = smeu_pkg::ST_UNDERFLOW;
            else if ((op_w == smeu_pkg::OP_DIV || op_w == smeu_pkg::OP_MOD) && b_ff == 0)
               ex_st = smeu_pkg::ST_DIV_ZERO;
            else if (op_w == smeu_pkg::OP_DIV || op_w == smeu_pkg::OP_MOD) ex_iter = 1'b1;
            ex_r = (op_w == smeu_pkg::OP_ADD) ? a_ff + b_ff
                 : (op_w == smeu_pkg::OP_SUB) ? a_ff - b_ff : prod;
         end
         smeu_pkg::OP_SQRT, smeu_pkg::OP_SQR: begin
            if (dd_ff == 0) ex_st = smeu_pkg::ST_UNDERFLOW;
            else if (op_w == smeu_pkg::OP_SQRT && !b_ff[W-1]) ex_iter = 1'b1;
            ex_r = (op_w == smeu_pkg::OP_SQR) ? prod : '0;
         end
         smeu_pkg::OP_OUT: ex_outok = (dd_ff != 0);
         smeu_pkg::OP_JMP: begin
            if (!tgt_ok(imm_ff, plen_ff)) ex_st = smeu_pkg::ST_BAD_JUMP;
            ex_npc = imm_ff[PW-1:0];
         end
         smeu_pkg::OP_JB, smeu_pkg::OP_JBE, smeu_pkg::OP_JA, smeu_pkg::OP_JAE,
         smeu_pkg::OP_JE, smeu_pkg::OP_JNE: begin
            if (dd_ff < 2) ex_st = smeu_pkg::ST_UNDERFLOW;
            else if (take) begin
               if (!tgt_ok(imm_ff, plen_ff)) ex_st = smeu_pkg::ST_BAD_JUMP;
               ex_npc = imm_ff[PW-1:0];
            end
         end
         smeu_pkg::OP_CALL: begin
            if (rd_ff >= (CSA+1)'(CALL_STACK_DEPTH)) ex_st = smeu_pkg::ST_OVERFLOW;
            else if (!tgt_ok(imm_ff, plen_ff)) ex_st = smeu_pkg::ST_BAD_JUMP;
            ex_npc = imm_ff[PW-1:0];
         end
         smeu_pkg::OP_RET: begin
            if (rd_ff == 0) ex_st = smeu_pkg::ST_UNDERFLOW;
            else if (!tgt_ok({19'd0, ret_ff}, plen_ff)) ex_st = smeu_pkg::ST_BAD_JUMP;
            ex_npc = ret_ff;
         end
         default: ;
      endcase
   end

   assign ireq.start   = (state_ff == S_EXEC) && ex_iter && ex_st == smeu_pkg::ST_OK;
   assign ireq.is_sqrt = (op_w == smeu_pkg::OP_SQRT);
   assign ireq.is_mod  = (op_w == smeu_pkg::OP_MOD);
   assign ireq.a       = a_ff;
   assign ireq.b       = b_ff;

   logic [DSA-1:0] top_idx, sec_idx, push_idx;
   assign top_idx  = DSA'(dd_ff - 1'b1);
   assign sec_idx  = DSA'(dd_ff - 2'd2);
   assign push_idx = dd_ff[DSA-1:0];

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; pc_ff <= '0; dd_ff <= '0; rd_ff <= '0;
         fault_ff <= 1'b0; rv_ff <= 1'b0; plen_ff <= PW'(CODE_WORDS);
      end else begin
         if (csr_we) plen_ff <= csr_wdata;
         // Load the result item once the output register is free; drop valid when taken
         if (state_ff == S_DONE && (!rv_ff || rsp_tready)) begin
            rv_ff <= 1'b1;
            rdata_ff <= {7'd0, st_ff, outv_ff, outok_ff, npc_ff};
         end else if (rv_ff && rsp_tready) begin
            rv_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               // Sweep RAM and registers to zero
               ram[clr_ff[RA-1:0]] <= '0;
               if (clr_ff < (RA+1)'(8)) regs[clr_ff[2:0]] <= '0;
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (RA+1)'(RAM_WORDS-1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (req_tvalid && req_tready) begin
               op_ff <= req_tdata[4:0]; imm_ff <= req_tdata[36:5]; ent_ff <= req_tdata[68:37];
               state_ff <= fault_ff ? S_DONE : S_READ;
               st_ff <= smeu_pkg::ST_HALTED; npc_ff <= pc_ff; outok_ff <= 1'b0; outv_ff <= '0;
               regv_ff <= regs[req_tdata[7:5]];
            end
            S_READ: begin
               b_ff <= dstack[top_idx]; a_ff <= dstack[sec_idx];
               ret_ff <= cstack[CSA'(rd_ff - 1'b1)];
               ramv_ff <= ram[regv_ff[RA-1:0]];
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               st_ff <= ex_st; r_ff <= ex_r; npc_ff <= ex_npc;
               outok_ff <= ex_outok; outv_ff <= ex_outok ? b_ff : '0;
               state_ff <= (ireq.start) ? S_ITER : S_WRITE;
            end
            S_ITER: if (irsp.done) begin
               r_ff <= irsp.result; state_ff <= S_WRITE;
            end
            S_WRITE: begin
               if (st_ff != smeu_pkg::ST_OK) begin
                  fault_ff <= 1'b1; npc_ff <= pc_ff; outok_ff <= 1'b0; outv_ff <= '0;
               end else begin
                  pc_ff <= npc_ff;
                  case (op_w)
                     smeu_pkg::OP_PUSH, smeu_pkg::OP_PUSHR, smeu_pkg::OP_PUSHM,
                     smeu_pkg::OP_IN: begin
                        dstack[push_idx] <= r_ff; dd_ff <= dd_ff + 1'b1;
                     end
                     smeu_pkg::OP_POPR: if (dd_ff != 0) begin
                        regs[imm_ff[2:0]] <= b_ff; dd_ff <= dd_ff - 1'b1;
                     end
                     smeu_pkg::OP_POPM: begin
                        ram[regv_ff[RA-1:0]] <= b_ff; dd_ff <= dd_ff - 1'b1;
                     end
                     smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_DIV,
                     smeu_pkg::OP_MOD: begin
                        dstack[sec_idx] <= r_ff; dd_ff <= dd_ff - 1'b1;
                     end
                     smeu_pkg::OP_SQRT, smeu_pkg::OP_SQR: dstack[top_idx] <= r_ff;
                     smeu_pkg::OP_OUT: if (dd_ff != 0) dd_ff <= dd_ff - 1'b1;
                     smeu_pkg::OP_JB, smeu_pkg::OP_JBE, smeu_pkg::OP_JA, smeu_pkg::OP_JAE,
                     smeu_pkg::OP_JE, smeu_pkg::OP_JNE: dd_ff <= dd_ff - 2'd2;
                     smeu_pkg::OP_CALL: begin
                        cstack[rd_ff[CSA-1:0]] <= pc_next; rd_ff <= rd_ff + 1'b1;
                     end
                     smeu_pkg::OP_RET: rd_ff <= rd_ff - 1'b1;
                     default: ;
                  endcase
               end
               state_ff <= S_DONE;
            end
            S_DONE: if (!rv_ff || rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rdata_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      dd_ff <= (DSA+1)'(DATA_STACK_DEPTH)) else $error("data depth past capacity");
   a_call_bound: assert property (@(posedge clock) disable iff (reset)
      rd_ff <= (CSA+1)'(CALL_STACK_DEPTH)) else $error("call depth past capacity");
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      fault_ff |=> fault_ff) else $error("fault cleared without reset");
   a_pc_held_fault: assert property (@(posedge clock) disable iff (reset)
      $past(fault_ff) |-> $stable(pc_ff)) else $error("pc moved while halted");
endmodule

// File: dv/stack_machine_execute_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_tb
// Drives instruction items into the execute unit, runs a model of the machine
// state beside it and compares every result item field by field.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit_tb;

   localparam int DSTACK = 64;
   localparam int CSTACK = 32;
   localparam int NREGS = 8;
   localparam int RAMW = 1024;
   localparam int CODEW = 4096;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] out_value;
      logic        out_valid;
      logic [12:0] next_pc;
   } exec_result_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [12:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;

   // machine state copy
   logic [12:0] m_prog_len;
   logic [12:0] m_pc;
   logic [31:0] m_dstack [DSTACK];
   int          m_ddepth;
   logic [12:0] m_cstack [CSTACK];
   int          m_cdepth;
   logic [31:0] m_regs [NREGS];
   logic [31:0] m_ram [RAMW];
   bit          m_faulted;

   exec_result_type expected_results[$];
   int          mismatches;
   bit          timed_out;
   int          idle_cycles;
   bit          calm;

   stack_machine_execute_unit dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] isqrt(logic [31:0] v);
      logic [31:0] res, bitv;
      res = 0;
      bitv = 32'h4000_0000;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic bit target_valid(logic [31:0] t);
      return !t[31] && t <= {19'd0, m_prog_len};
   endfunction

   // Execute one instruction on the state copy and return its result
   function automatic exec_result_type execute(logic [4:0] op, logic [31:0] imm,
                                               logic [31:0] entered);
      exec_result_type res;
      logic [12:0] npc;
      logic [2:0] st;
      logic [31:0] a, b, r, ma, mb, addr;
      bit reg_ok, take;
      logic signed [31:0] sa, sb;
      st = smeu_pkg::ST_OK;
      res = '0;
      a = 0;
      b = 0;
      r = 0;
      take = 0;
      reg_ok = imm < NREGS;
      if (op <= smeu_pkg::OP_POPM || (op >= smeu_pkg::OP_JMP && op <= smeu_pkg::OP_CALL))
         npc = m_pc + 13'd2;
      else npc = m_pc + 13'd1;
      if (m_faulted) begin
         res.next_pc = m_pc;
         res.status = smeu_pkg::ST_HALTED;
         return res;
      end
      if (m_ddepth >= 1) b = m_dstack[m_ddepth-1];
      if (m_ddepth >= 2) a = m_dstack[m_ddepth-2];
      sa = a;
      sb = b;
      case (op)
         smeu_pkg::OP_PUSH, smeu_pkg::OP_PUSHR, smeu_pkg::OP_PUSHM, smeu_pkg::OP_IN: begin
            if ((op == smeu_pkg::OP_PUSHR || op == smeu_pkg::OP_PUSHM) && !reg_ok)
               st = smeu_pkg::ST_BAD_REG;
            else if (op == smeu_pkg::OP_PUSHM && m_regs[imm[2:0]] >= RAMW)
               st = smeu_pkg::ST_BAD_ADDR;
            else if (m_ddepth >= DSTACK) st = smeu_pkg::ST_OVERFLOW;
            else begin
               if (op == smeu_pkg::OP_PUSH) r = imm;
               else if (op == smeu_pkg::OP_PUSHR) r = m_regs[imm[2:0]];
               else if (op == smeu_pkg::OP_PUSHM) r = m_ram[m_regs[imm[2:0]][9:0]];
               else r = entered;
               m_dstack[m_ddepth] = r;
               m_ddepth++;
            end
         end
         smeu_pkg::OP_POPR: begin
            if (m_ddepth != 0) begin
               if (!reg_ok) st = smeu_pkg::ST_BAD_REG;
               else begin
                  m_regs[imm[2:0]] = b;
                  m_ddepth--;
               end
            end
         end
         smeu_pkg::OP_POPM: begin
            if (!reg_ok) st = smeu_pkg::ST_BAD_REG;
            else if (m_regs[imm[2:0]] >= RAMW) st = smeu_pkg::ST_BAD_ADDR;
            else if (m_ddepth == 0) st = smeu_pkg::ST_UNDERFLOW;
            else begin
               addr = m_regs[imm[2:0]];
               m_ram[addr[9:0]] = b;
               m_ddepth--;
            end
         end
         smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_DIV,
         smeu_pkg::OP_MOD: begin
            if (m_ddepth < 2) st = smeu_pkg::ST_UNDERFLOW;
            else if ((op == smeu_pkg::OP_DIV || op == smeu_pkg::OP_MOD) && b == 0)
               st = smeu_pkg::ST_DIV_ZERO;
            else begin
               ma = a[31] ? -a : a;
               mb = b[31] ? -b : b;
               case (op)
                  smeu_pkg::OP_ADD: r = a + b;
                  smeu_pkg::OP_SUB: r = a - b;
                  smeu_pkg::OP_MUL: r = a * b;
                  smeu_pkg::OP_DIV: begin
                     r = ma / mb;
                     if (a[31] ^ b[31]) r = -r;
                  end
                  default: begin
                     r = ma % mb;
                     if (a[31]) r = -r;
                  end
               endcase
               m_ddepth--;
               m_dstack[m_ddepth-1] = r;
            end
         end
         smeu_pkg::OP_SQRT, smeu_pkg::OP_SQR: begin
            if (m_ddepth == 0) st = smeu_pkg::ST_UNDERFLOW;
            else begin
               if (op == smeu_pkg::OP_SQR) r = b * b;
               else r = b[31] ? 32'd0 : isqrt(b);
               m_dstack[m_ddepth-1] = r;
            end
         end
         smeu_pkg::OP_OUT: begin
            if (m_ddepth != 0) begin
               res.out_valid = 1;
               res.out_value = b;
               m_ddepth--;
            end
         end
         smeu_pkg::OP_JMP: begin
            if (!target_valid(imm)) st = smeu_pkg::ST_BAD_JUMP;
            else npc = imm[12:0];
         end
         smeu_pkg::OP_JB, smeu_pkg::OP_JBE, smeu_pkg::OP_JA, smeu_pkg::OP_JAE,
         smeu_pkg::OP_JE, smeu_pkg::OP_JNE: begin
            if (m_ddepth < 2) st = smeu_pkg::ST_UNDERFLOW;
            else begin
               case (op)
                  smeu_pkg::OP_JB: take = sa < sb;
                  smeu_pkg::OP_JBE: take = sa <= sb;
                  smeu_pkg::OP_JA: take = sa > sb;
                  smeu_pkg::OP_JAE: take = sa >= sb;
                  smeu_pkg::OP_JE: take = sa == sb;
                  default: take = sa != sb;
               endcase
               if (take && !target_valid(imm)) st = smeu_pkg::ST_BAD_JUMP;
               else begin
                  if (take) npc = imm[12:0];
                  m_ddepth -= 2;
               end
            end
         end
         smeu_pkg::OP_CALL: begin
            if (m_cdepth >= CSTACK) st = smeu_pkg::ST_OVERFLOW;
            else if (!target_valid(imm)) st = smeu_pkg::ST_BAD_JUMP;
            else begin
               m_cstack[m_cdepth] = npc;
               m_cdepth++;
               npc = imm[12:0];
            end
         end
         smeu_pkg::OP_RET: begin
            if (m_cdepth == 0) st = smeu_pkg::ST_UNDERFLOW;
            else if (!target_valid({19'd0, m_cstack[m_cdepth-1]})) st = smeu_pkg::ST_BAD_JUMP;
            else begin
               m_cdepth--;
               npc = m_cstack[m_cdepth];
            end
         end
         default: ;
      endcase
      if (st != smeu_pkg::ST_OK) begin
         m_faulted = 1;
         npc = m_pc;
         res.out_valid = 0;
         res.out_value = 0;
      end
      m_pc = npc;
      res.next_pc = npc;
      res.status = st;
      return res;
   endfunction

   task automatic machine_reset();
      m_prog_len = 13'(CODEW);
      m_pc = 0;
      m_ddepth = 0;
      m_cdepth = 0;
      m_faulted = 0;
      foreach (m_regs[i]) m_regs[i] = 0;
      foreach (m_ram[i]) m_ram[i] = 0;
   endtask

   // Send one instruction item and record its expected result
   task automatic send_instr(logic [4:0] op, logic [31:0] imm, logic [31:0] entered);
      while (!calm && $urandom_range(99) < 8) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {3'd0, entered, imm, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(execute(op, imm, entered));
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (expected_results.size() != 0 && !timed_out) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_prog_len(logic [12:0] v);
      drain();
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      m_prog_len = v;
   endtask

   // Fault recovery is impossible without reset, so runs avoid errors
   // except in the closing fault test.
   function automatic logic [31:0] rand_word();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return $urandom_range(20);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_instr(smeu_pkg::OP_PUSH, 32'h8000_0000, 0);
      send_instr(smeu_pkg::OP_PUSH, 32'hffff_ffff, 0);
      send_instr(smeu_pkg::OP_DIV, 0, 0);
      send_instr(smeu_pkg::OP_PUSH, 32'h8000_0000, 0);
      send_instr(smeu_pkg::OP_PUSH, 32'hffff_ffff, 0);
      send_instr(smeu_pkg::OP_MOD, 0, 0);
      send_instr(smeu_pkg::OP_SQRT, 0, 0);
      send_instr(smeu_pkg::OP_IN, 0, 32'h7fff_ffff);
      send_instr(smeu_pkg::OP_SQRT, 0, 0);
      send_instr(smeu_pkg::OP_SQR, 0, 0);
      send_instr(smeu_pkg::OP_OUT, 0, 0);
      send_instr(smeu_pkg::OP_OUT, 0, 0);
      send_instr(smeu_pkg::OP_OUT, 0, 0);
      send_instr(smeu_pkg::OP_OUT, 0, 0);
      send_instr(smeu_pkg::OP_POPR, 32'hffff_ffff, 0);
      send_instr(5'd31, 0, 0);
      send_instr(smeu_pkg::OP_PUSH, 5, 0);
      send_instr(smeu_pkg::OP_POPR, 7, 0);
      send_instr(smeu_pkg::OP_PUSH, 32'hdead_beef, 0);
      send_instr(smeu_pkg::OP_POPM, 7, 0);
      send_instr(smeu_pkg::OP_PUSHM, 7, 0);
      send_instr(smeu_pkg::OP_PUSHR, 7, 0);
      send_instr(smeu_pkg::OP_JE, CODEW, 0);
      send_instr(smeu_pkg::OP_CALL, 100, 0);
      send_instr(smeu_pkg::OP_RET, 0, 0);
   endtask

   // Random well-formed instruction stream that never faults
   task automatic test_random(int count);
      int op, imm;
      for (int n = 0; n < count; n++) begin
         calm = (n > count / 2 && n < count / 2 + 120);
         if (n == count / 3) drain();
         op = $urandom_range(22);
         imm = rand_word();
         case (op)
            smeu_pkg::OP_PUSH, smeu_pkg::OP_IN, smeu_pkg::OP_PUSHR: begin
               if (m_ddepth >= DSTACK) op = smeu_pkg::OP_OUT;
               if (op == smeu_pkg::OP_PUSHR) imm = $urandom_range(NREGS-1);
            end
            smeu_pkg::OP_POPR: imm = $urandom_range(NREGS-1);
            smeu_pkg::OP_PUSHM, smeu_pkg::OP_POPM: begin
               imm = $urandom_range(NREGS-1);
               if (m_regs[imm] >= RAMW) begin
                  if (m_ddepth >= DSTACK) op = smeu_pkg::OP_OUT;
                  else begin
                     send_instr(smeu_pkg::OP_PUSH, $urandom_range(RAMW-1), 0);
                     op = smeu_pkg::OP_POPR;
                  end
               end else if (op == smeu_pkg::OP_PUSHM && m_ddepth >= DSTACK)
                  op = smeu_pkg::OP_OUT;
               else if (op == smeu_pkg::OP_POPM && m_ddepth == 0) op = smeu_pkg::OP_IN;
            end
            smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_DIV,
            smeu_pkg::OP_MOD, smeu_pkg::OP_JB, smeu_pkg::OP_JBE, smeu_pkg::OP_JA,
            smeu_pkg::OP_JAE, smeu_pkg::OP_JE, smeu_pkg::OP_JNE: begin
               if (m_ddepth < 2 || ((op == smeu_pkg::OP_DIV || op == smeu_pkg::OP_MOD)
                                    && m_dstack[m_ddepth-1] == 0)) op = smeu_pkg::OP_IN;
               if (op >= smeu_pkg::OP_JB) imm = $urandom_range(m_prog_len);
            end
            smeu_pkg::OP_SQRT, smeu_pkg::OP_SQR: if (m_ddepth == 0) op = smeu_pkg::OP_IN;
            smeu_pkg::OP_JMP: imm = $urandom_range(m_prog_len);
            smeu_pkg::OP_CALL: begin
               if (m_cdepth >= CSTACK)
                  op = (m_cstack[m_cdepth-1] > m_prog_len) ? smeu_pkg::OP_OUT
                                                           : smeu_pkg::OP_RET;
               imm = $urandom_range(m_prog_len);
            end
            smeu_pkg::OP_RET:
               if (m_cdepth == 0 || m_cstack[m_cdepth-1] > m_prog_len) op = smeu_pkg::OP_OUT;
            default: ;
         endcase
         if (op == smeu_pkg::OP_IN && m_ddepth >= DSTACK) op = smeu_pkg::OP_OUT;
         send_instr(5'(op), imm, rand_word());
      end
      calm = 0;
   endtask

   // Fill the data stack then overflow it; halted items follow
   task automatic test_fault();
      while (m_ddepth < DSTACK) send_instr(smeu_pkg::OP_PUSH, $urandom, 0);
      send_instr(smeu_pkg::OP_IN, 0, $urandom);
      repeat (3) send_instr(5'($urandom_range(22)), $urandom, $urandom);
   endtask

   // Check each result against the oldest expectation
   initial begin
      exec_result_type got, want;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[48:0];
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch pc %h/%h ov %b/%b val %h/%h st %0d/%0d",
                              want.next_pc, got.next_pc, want.out_valid,
                              got.out_valid, want.out_value, got.out_value,
                              want.status, got.status);
               end
            end
         end
      end
   end

   // Randomly stall the result side
   initial begin
      rsp_tready = 0;
      forever begin
         @(posedge clock);
         rsp_tready <= calm || ($urandom_range(99) >= 8);
      end
   end

   // Watchdog on cycles with nothing accepted
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            timed_out = 1;
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      reset = 1;
      csr_we = 0;
      csr_wdata = 0;
      req_tvalid = 0;
      req_tdata = 0;
      calm = 0;
      mismatches = 0;
      timed_out = 0;
      machine_reset();
      repeat (4) @(posedge clock);
      reset <= 0;
      test_directed();
      write_prog_len(13'd0);
      test_random(40);
      write_prog_len(13'h1fff);
      test_random(300);
      write_prog_len(13'd37);
      test_random(200);
      write_prog_len(13'(CODEW));
      test_random(260);
      test_fault();
      drain();
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
